[src/sacl_pkg.sv]
// Package with the shared constants, types and codes of the cache timing lookup.
package sacl_pkg;

    localparam int NUM_SETS   = 32;
    localparam int NUM_WAYS   = 4;
    localparam int LINE_BYTES = 64;

    localparam int ADDR_W   = 64;
    localparam int TIME_W   = 64;
    localparam int LAT_W    = 16;
    localparam int OFFSET_W = $clog2(LINE_BYTES);
    localparam int SET_W    = $clog2(NUM_SETS);
    localparam int WAY_W    = $clog2(NUM_WAYS);
    localparam int TAG_W    = ADDR_W - OFFSET_W - SET_W;
    localparam int OUT_WAY_W = 2;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam int S_DATA_W = ADDR_W + TIME_W;
    localparam int M_DATA_W = 24;

    localparam logic [LAT_W-1:0] HIT_LAT_RESET  = LAT_W'(2);
    localparam logic [LAT_W-1:0] MISS_LAT_RESET = LAT_W'(30);
    localparam logic [LAT_W-1:0] LAT_MAX        = {LAT_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_HIT_LAT  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MISS_LAT = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        OUT_READY_HIT   = 2'd0,
        OUT_PENDING_HIT = 2'd1,
        OUT_MISS        = 2'd2
    } outcome_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOOKUP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic commit;
    } dp_cmd_t;

endpackage

[src/sacl_ctrl.sv]
// Controller state machine that sequences one access through read, compare and update.
module sacl_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output sacl_pkg::dp_cmd_t cmd
);
    import sacl_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_LOOKUP;
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // The result may only move into the output register once it is free.
                if (!out_valid_reg || m_tready)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

`ifndef SYNTHESIS
    a_accept_to_read: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_READ))
        else $error("accepted beat did not start a memory read");

    a_read_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> (state_reg == ST_LOOKUP))
        else $error("memory read not followed by way compare");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (m_tvalid && state_reg == ST_IDLE))
        else $error("committed result not presented on the output");
`endif

endmodule

[src/sacl_dpath.sv]
// Datapath with tag and fill-time memories, valid and LRU state, and result register.
module sacl_dpath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sacl_pkg::dp_cmd_t                 cmd,
    input  logic [sacl_pkg::ADDR_W-1:0]       address,
    input  logic [sacl_pkg::TIME_W-1:0]       now,
    input  logic                              cfg_we,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic [sacl_pkg::LAT_W-1:0]        latency,
    output logic [1:0]                        outcome,
    output logic [sacl_pkg::OUT_WAY_W-1:0]    way
);
    import sacl_pkg::*;

    logic [LAT_W-1:0]  hit_lat_reg, miss_lat_reg;
    logic [ADDR_W-1:0] address_reg;
    logic [TIME_W-1:0] now_reg;

    logic [TAG_W-1:0]  tag_mem   [NUM_SETS][NUM_WAYS];
    logic [TIME_W-1:0] ready_mem [NUM_SETS][NUM_WAYS];
    logic [TAG_W-1:0]  tag_rd_reg   [NUM_WAYS];
    logic [TIME_W-1:0] ready_rd_reg [NUM_WAYS];

    logic              valid_reg [NUM_SETS][NUM_WAYS];
    logic [WAY_W-1:0]  lru_reg   [NUM_SETS][NUM_WAYS];

    logic              hit_reg;
    logic [WAY_W-1:0]  sel_way_reg;
    logic [TIME_W-1:0] avail_reg;

    logic [LAT_W-1:0]  latency_reg;
    outcome_t          outcome_reg;
    logic [WAY_W-1:0]  way_reg;

    logic [SET_W-1:0]  set_idx;
    logic [TAG_W-1:0]  tag;
    logic              hit;
    logic [WAY_W-1:0]  hit_way;
    logic [WAY_W-1:0]  victim;
    logic [WAY_W-1:0]  pick_way;
    logic [TIME_W:0]   diff;
    logic              pending;
    logic [TIME_W-1:0] fill_time;
    logic [LAT_W-1:0]  pend_lat;
    logic [WAY_W-1:0]  pos;
    logic [WAY_W-1:0]  ord_next [NUM_WAYS];

    assign set_idx = address_reg[OFFSET_W +: SET_W];
    assign tag     = address_reg[ADDR_W-1 -: TAG_W];

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_lat_reg  <= HIT_LAT_RESET;
            miss_lat_reg <= MISS_LAT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HIT_LAT:  hit_lat_reg  <= cfg_data;
                REG_MISS_LAT: miss_lat_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            address_reg <= address;
            now_reg     <= now;
        end
    end

    // Memories: whole set row read every cycle, one way written on a miss.
    always_ff @(posedge clk)
    begin
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            tag_rd_reg[w]   <= tag_mem[set_idx][w];
            ready_rd_reg[w] <= ready_mem[set_idx][w];
        end
        if (cmd.commit && !hit_reg)
        begin
            tag_mem[set_idx][sel_way_reg]   <= tag;
            ready_mem[set_idx][sel_way_reg] <= fill_time;
        end
    end

    // Lowest-numbered matching way wins.
    always_comb
    begin
        hit     = 1'b0;
        hit_way = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (valid_reg[set_idx][w] && tag_rd_reg[w] == tag)
            begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
        end
    end

    assign victim   = lru_reg[set_idx][NUM_WAYS-1];
    assign pick_way = hit ? hit_way : victim;

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            hit_reg     <= hit;
            sel_way_reg <= pick_way;
            avail_reg   <= ready_rd_reg[pick_way];
        end
    end

    assign diff      = {1'b0, avail_reg} - {1'b0, now_reg};
    assign pending   = !diff[TIME_W] && (diff[TIME_W-1:0] != '0);
    assign pend_lat  = (diff[TIME_W-1:LAT_W] != '0) ? LAT_MAX : diff[LAT_W-1:0];
    assign fill_time = now_reg + TIME_W'(miss_lat_reg);

    // Move the selected way to the front of the recency order.
    always_comb
    begin
        pos = WAY_W'(NUM_WAYS - 1);
        for (int i = NUM_WAYS - 2; i >= 0; i--)
        begin
            if (lru_reg[set_idx][i] == sel_way_reg)
            begin
                pos = WAY_W'(i);
            end
        end
        ord_next[0] = sel_way_reg;
        for (int i = 1; i < NUM_WAYS; i++)
        begin
            if (WAY_W'(i) <= pos)
            begin
                ord_next[i] = lru_reg[set_idx][i-1];
            end
            else
            begin
                ord_next[i] = lru_reg[set_idx][i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_SETS; s++)
            begin
                for (int w = 0; w < NUM_WAYS; w++)
                begin
                    valid_reg[s][w] <= 1'b0;
                    lru_reg[s][w]   <= WAY_W'(w);
                end
            end
        end
        else if (cmd.commit)
        begin
            if (!hit_reg)
            begin
                valid_reg[set_idx][sel_way_reg] <= 1'b1;
            end
            for (int w = 0; w < NUM_WAYS; w++)
            begin
                lru_reg[set_idx][w] <= ord_next[w];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            way_reg <= sel_way_reg;
            if (!hit_reg)
            begin
                latency_reg <= miss_lat_reg;
                outcome_reg <= OUT_MISS;
            end
            else if (pending)
            begin
                latency_reg <= pend_lat;
                outcome_reg <= OUT_PENDING_HIT;
            end
            else
            begin
                latency_reg <= hit_lat_reg;
                outcome_reg <= OUT_READY_HIT;
            end
        end
    end

    assign latency = latency_reg;
    assign outcome = outcome_reg;
    assign way     = OUT_WAY_W'(way_reg);

endmodule

[src/set_assoc_cache_timing_lookup_top.sv]
// Top level of the 4-way set-associative cache timing lookup with true-LRU replacement.
//
//  Channel   Direction  Handshake           Payload
//  s_*       in         s_tvalid/s_tready   s_tdata: address[63:0], now[127:64]
//  m_*       out        m_tvalid/m_tready   m_tdata: latency[15:0], outcome[17:16],
//                                           way[19:18], zero fill [23:20]
//  cfg_*     in         cfg_we              cfg_index selects the register, cfg_data
//
// Each access passes through four steps: the accept beat, a registered read of the set row in
// the tag and fill-time memories, the parallel way compare, and the result and update
// step, so a new access is accepted only once the previous one has left its update step.
// The output register lets the next access enter while a result waits; a stalled output
// holds the finished access in its update cycle until the register frees.
// Reset clears the valid bits and the LRU order at once; no clearing pass is needed.
module set_assoc_cache_timing_lookup_top (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input beat, from the lowest bit up: address, now.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [sacl_pkg::S_DATA_W-1:0]     s_tdata,
    // Result beat, from the lowest bit up: latency, outcome, way, zero fill.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sacl_pkg::M_DATA_W-1:0]     m_tdata,
    // Configuration writes: index 0 is hit latency, index 1 is miss latency.
    input  logic                              cfg_we,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import sacl_pkg::*;

    dp_cmd_t               cmd;
    logic [LAT_W-1:0]      latency;
    logic [1:0]            outcome;
    logic [OUT_WAY_W-1:0]  way;

    // The controller sequences each access and owns the output valid flag.
    sacl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // The datapath holds the cache state, the configuration and the result payload.
    sacl_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .address   (s_tdata[ADDR_W-1:0]),
        .now       (s_tdata[ADDR_W +: TIME_W]),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .latency   (latency),
        .outcome   (outcome),
        .way       (way)
    );

    assign m_tdata = {{(M_DATA_W - LAT_W - 2 - OUT_WAY_W){1'b0}}, way, outcome, latency};

endmodule

[dv/tb_set_assoc_cache_timing_lookup_top.sv]
// Self-checking testbench for the set-associative cache timing lookup top level.
module tb_set_assoc_cache_timing_lookup_top;

    timeunit 1ns;
    timeprecision 1ps;

    import sacl_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 9;
    // Settle time after draining, covering an access inside the block and the output register.
    localparam int SETTLE_CYCLES  = 8;
    // Long receiver hold-off, so that the block fills up and stalls its input.
    localparam int HOLD_CYCLES    = 300;
    // Cycles without any beat before the run is declared hung. The longest legal quiet
    // stretch is the hold-off above plus a few configuration and settle cycles.
    localparam int WATCHDOG_LIMIT = 5000;

    // One predicted lookup result, in the field order of the result beat.
    typedef struct {
        logic [LAT_W-1:0]     latency;
        outcome_t             outcome;
        logic [OUT_WAY_W-1:0] way;
    } lookup_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // Input beat, from the lowest bit up: address, now.
    logic [S_DATA_W-1:0]   s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // Result beat, from the lowest bit up: latency, outcome, way, zero fill.
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_HIT_LAT;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Shadow copy of the cache: tags, valid bits, fill completion times and the
    // recency order of each set (position 0 is the most recently used way).
    logic [TAG_W-1:0]  line_tag   [NUM_SETS][NUM_WAYS];
    logic              line_valid [NUM_SETS][NUM_WAYS];
    logic [TIME_W-1:0] line_ready [NUM_SETS][NUM_WAYS];
    int                lru_order  [NUM_SETS][NUM_WAYS];
    logic [LAT_W-1:0]  hit_lat;
    logic [LAT_W-1:0]  miss_lat;

    // Accesses waiting to be driven, and lookup results predicted but not yet seen.
    logic [S_DATA_W-1:0] access_queue[$];
    lookup_result_t      lookup_results_due[$];

    int accesses_queued  = 0;
    int accesses_taken   = 0;
    int mismatch_count   = 0;
    int stall_cycles     = 0;
    int sender_idle_pct  = 10;
    int receiver_idle_pct = 48;
    int hold_requests    = 0;
    int holds_served     = 0;
    int hold_left        = 0;
    logic in_beat_taken  = 1'b0;

    set_assoc_cache_timing_lookup_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Looks up one access in the shadow cache and updates it the way the block must:
    // a hit reports either the hit latency or the cycles left on the fill, a miss
    // replaces the least recently used way, and the chosen way becomes most recent.
    function automatic lookup_result_t cache_lookup(input logic [ADDR_W-1:0] addr,
                                                    input logic [TIME_W-1:0] now);
        logic [SET_W-1:0]  set_idx;
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] remaining;
        int                way;
        int                pos;
        lookup_result_t    res;
        set_idx = addr[OFFSET_W +: SET_W];
        tag     = addr[ADDR_W-1 -: TAG_W];
        way     = -1;
        // Scanning downward leaves the lowest matching way in hand.
        for (int w = NUM_WAYS - 1; w >= 0; w--)
            if (line_valid[set_idx][w] && line_tag[set_idx][w] == tag)
                way = w;
        if (way >= 0)
        begin
            if (line_ready[set_idx][way] <= now)
            begin
                res.latency = hit_lat;
                res.outcome = OUT_READY_HIT;
            end
            else
            begin
                remaining   = line_ready[set_idx][way] - now;
                res.latency = (remaining > TIME_W'(LAT_MAX)) ? LAT_MAX : remaining[LAT_W-1:0];
                res.outcome = OUT_PENDING_HIT;
            end
        end
        else
        begin
            way = lru_order[set_idx][NUM_WAYS-1];
            line_valid[set_idx][way] = 1'b1;
            line_tag[set_idx][way]   = tag;
            // The fill time is a plain 64-bit sum and wraps past the top of the range.
            line_ready[set_idx][way] = now + TIME_W'(miss_lat);
            res.latency = miss_lat;
            res.outcome = OUT_MISS;
        end
        res.way = OUT_WAY_W'(way);
        pos = 0;
        while (pos < NUM_WAYS - 1 && lru_order[set_idx][pos] != way)
            pos++;
        for (int i = pos; i > 0; i--)
            lru_order[set_idx][i] = lru_order[set_idx][i-1];
        lru_order[set_idx][0] = way;
        return res;
    endfunction

    function automatic logic [ADDR_W-1:0] line_addr(input logic [TAG_W-1:0]    tag,
                                                    input logic [SET_W-1:0]    set_idx,
                                                    input logic [OFFSET_W-1:0] offset);
        return {tag, set_idx, offset};
    endfunction

    task automatic queue_access(input logic [ADDR_W-1:0] addr, input logic [TIME_W-1:0] now);
        access_queue.push_back({now, addr});
        accesses_queued++;
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want,
                 accesses_taken - lookup_results_due.size());
        mismatch_count++;
    endtask

    // Writes both latency registers; only called while the block is idle.
    task automatic set_latencies(input logic [LAT_W-1:0] hit_val,
                                 input logic [LAT_W-1:0] miss_val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_HIT_LAT;
        cfg_data  <= hit_val;
        @(negedge clk);
        cfg_index <= REG_MISS_LAT;
        cfg_data  <= miss_val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Blocks until every queued access has been taken and every result has come back,
    // then lets the block settle.
    task automatic wait_drained;
        @(negedge clk);
        while (accesses_taken != accesses_queued || lookup_results_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Mostly well-formed traffic: a handful of tags over a few sets, so that lines get
    // hit, hit while still filling and evicted, with the cycle count mostly moving forward
    // and sometimes jumping back. One access in five is fully random noise.
    task automatic queue_random_accesses(input int count, input logic [TIME_W-1:0] start);
        logic [TAG_W-1:0]  tag_base;
        logic [TIME_W-1:0] cycle;
        logic [SET_W-1:0]  set_idx;
        int                pick;
        tag_base = TAG_W'({$urandom, $urandom});
        cycle    = start;
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 20)
                queue_access({$urandom, $urandom}, {$urandom, $urandom});
            else
            begin
                if (pick < 28)
                    cycle -= TIME_W'($urandom_range(2000));
                else
                    cycle += TIME_W'($urandom_range(40));
                if ($urandom_range(9) == 0)
                    set_idx = SET_W'($urandom_range(NUM_SETS - 1));
                else
                    set_idx = SET_W'($urandom_range(3));
                queue_access(line_addr(tag_base ^ TAG_W'($urandom_range(5)), set_idx,
                                       OFFSET_W'($urandom)), cycle);
            end
        end
    endtask

    // Driver: presents the next pending access once the current beat has been taken,
    // idling at random between beats.
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || in_beat_taken)
        begin
            if (access_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                s_tdata  <= access_queue.pop_front();
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver: random back-pressure, plus a long hold-off whenever one is requested.
    always @(negedge clk)
    begin
        if (hold_requests != holds_served)
        begin
            holds_served = hold_requests;
            hold_left    = HOLD_CYCLES;
        end
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // Monitor: tracks register writes, predicts each accepted access and checks each
    // result beat against the oldest prediction.
    always @(posedge clk)
    begin : monitor
        lookup_result_t want;
        in_beat_taken = 1'b0;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_HIT_LAT)
                    hit_lat = cfg_data;
                else if (cfg_index == REG_MISS_LAT)
                    miss_lat = cfg_data;
            end
            if (m_tvalid && m_tready)
            begin
                if (lookup_results_due.size() == 0)
                    report_mismatch("result with no access waiting", 64'(m_tdata), 64'd0);
                else
                begin
                    want = lookup_results_due.pop_front();
                    if (m_tdata[LAT_W-1:0] !== want.latency)
                        report_mismatch("latency", 64'(m_tdata[LAT_W-1:0]),
                                        64'(want.latency));
                    if (m_tdata[LAT_W +: 2] !== want.outcome)
                        report_mismatch("outcome", 64'(m_tdata[LAT_W +: 2]),
                                        64'(want.outcome));
                    if (m_tdata[LAT_W + 2 +: OUT_WAY_W] !== want.way)
                        report_mismatch("way", 64'(m_tdata[LAT_W + 2 +: OUT_WAY_W]),
                                        64'(want.way));
                    if (m_tdata[M_DATA_W-1:LAT_W + 2 + OUT_WAY_W] !== '0)
                        report_mismatch("zero fill",
                                        64'(m_tdata[M_DATA_W-1:LAT_W + 2 + OUT_WAY_W]),
                                        64'd0);
                end
            end
            in_beat_taken = s_tvalid && s_tready;
            if (in_beat_taken)
            begin
                lookup_results_due.push_back(cache_lookup(s_tdata[ADDR_W-1:0],
                                                          s_tdata[S_DATA_W-1:ADDR_W]));
                accesses_taken++;
            end
        end
    end

    // Watchdog: ends the run when no beat moves on either side for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no beat for %0d cycles", stall_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        // The shadow cache starts empty, with way i at recency position i.
        for (int s = 0; s < NUM_SETS; s++)
            for (int w = 0; w < NUM_WAYS; w++)
            begin
                line_tag[s][w]   = '0;
                line_valid[s][w] = 1'b0;
                line_ready[s][w] = '0;
                lru_order[s][w]  = w;
            end
        hit_lat  = HIT_LAT_RESET;
        miss_lat = MISS_LAT_RESET;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Directed accesses under the reset latencies. A cold line with tag zero must
        // still miss, since nothing is valid after reset.
        queue_access(64'd0, 64'd0);
        queue_access(64'd0, 64'd5);                    // hit while the fill is pending
        queue_access(64'h3F, 64'd100);                 // ready hit on the last byte
        // All ones in both fields: the fill time wraps past the top of the range, so the
        // same line reads as pending at a small cycle count and ready at the top.
        queue_access('1, '1);
        queue_access('1, 64'd10);
        queue_access('1, '1);
        queue_access({1'b1, 63'd0}, 64'd0);            // top tag bit alone
        // Fill all four ways of one set, then force two evictions in LRU order.
        for (int t = 1; t <= 4; t++)
            queue_access(line_addr(TAG_W'(t), 5'd5, 6'd0), 64'd1000);
        queue_access(line_addr(TAG_W'(1), 5'd5, 6'd0), 64'd2000);
        queue_access(line_addr(TAG_W'(5), 5'd5, 6'd0), 64'd2000);
        queue_access(line_addr(TAG_W'(2), 5'd5, 6'd0), 64'd2000);
        queue_access(line_addr(TAG_W'(1), 5'd5, 6'd9), 64'd2001);
        // Remaining fill time around the saturation point, and a cycle count that has
        // moved backward far past it.
        queue_access(line_addr(TAG_W'(9), 5'd7, 6'd0), 64'd1000000);
        queue_access(line_addr(TAG_W'(9), 5'd7, 6'd1), 64'd1000030 - 64'd65535);
        queue_access(line_addr(TAG_W'(9), 5'd7, 6'd2), 64'd1000030 - 64'd65536);
        queue_access(line_addr(TAG_W'(9), 5'd7, 6'd3), 64'd0);
        queue_access(line_addr(TAG_W'(9), 5'd7, 6'd4), 64'd1000029);
        queue_access(line_addr(TAG_W'(9), 5'd7, 6'd5), 64'd1000030);
        queue_random_accesses(100, 64'd3000);
        wait_drained();

        // Zero latencies: a miss line is ready at the very cycle it was filled.
        set_latencies('0, '0);
        queue_random_accesses(110, 64'd5000);
        wait_drained();

        // Swap the idling sides and go to the largest latencies.
        sender_idle_pct   = 48;
        receiver_idle_pct = 10;
        set_latencies(LAT_MAX, LAT_MAX);
        queue_random_accesses(110, 64'd100000);
        wait_drained();

        // Random latencies with the cycle count close to wrapping.
        set_latencies(LAT_W'($urandom), LAT_W'($urandom));
        queue_random_accesses(110, 64'hFFFF_FFFF_FFFF_F000);
        wait_drained();

        // No idling. The receiver holds off while the sender keeps offering, so the
        // block backs up and stalls its input.
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        set_latencies(LAT_W'(1), LAT_W'(200));
        queue_random_accesses(120, {$urandom, $urandom});
        hold_requests++;
        wait_drained();

        set_latencies(LAT_W'($urandom_range(8)), LAT_W'($urandom_range(100)));
        queue_random_accesses(130, 64'd0);
        wait_drained();

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
